/* hdl/assert_macros.svh */
// Assertion macros for the RTL file of the epoch-to-calendar block.
// Uses the aclk clock and the aresetn reset of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/es2c_pkg.sv */
// Package for the epoch-to-calendar block: widths, divisors and month table.
// No dependencies.
package es2c_pkg;

    localparam int EPOCH_W = 32;
    localparam int REM_W   = 16;
    localparam int YEAR_W  = 12;
    localparam int DAY_W   = 9;

    localparam logic [REM_W-1:0] DIV_MINUTE = 16'd60;
    localparam logic [REM_W-1:0] DIV_QUAD   = 16'd35064;
    localparam logic [REM_W-1:0] DIV_DAY    = 16'd24;
    localparam logic [REM_W-1:0] HOURS_YEAR = 16'd8760;
    localparam logic [REM_W-1:0] HOURS_LEAP = 16'd8784;
    localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;

    // Division phases of the shared serial divider.
    typedef logic [1:0] phase_t;
    localparam phase_t PH_SEC  = 2'd0;
    localparam phase_t PH_MIN  = 2'd1;
    localparam phase_t PH_QUAD = 2'd2;
    localparam phase_t PH_HOUR = 2'd3;

    // Days in each month of a common year, January first.
    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd1:                     len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* hdl/epoch_seconds_to_calendar.sv */
// Top level of the epoch-to-calendar converter: serial divider and calendar walk.
// Depends on es2c_pkg and assert_macros.svh.
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// second, minute, hour, day of month, month (0 is January) and year. Every
// year divisible by four is treated as a leap year, so dates from March 2100
// on are one day earlier than the Gregorian calendar. One item is worked on at
// a time. A single restoring divider that produces one quotient bit per cycle
// does all the divisions: seconds by 60, minutes by 60 and hours by 35064 per
// four-year block; then at most three single years are stepped over, the hours
// left are divided by 24 and up to 11 steps walk the months. The result sits
// in an output register, so a new word is accepted as soon as the previous
// result has been moved there, even while it waits for m_tready.
`include "assert_macros.svh"

module epoch_seconds_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // epoch_seconds[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // second[5:0], minute[11:6], hour[16:12], day_of_month[21:17],
    // month_index[25:22], year[37:26], zero[39:38]
    output logic [39:0] m_tdata
);
    import es2c_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_YEAR = 3'd2;
    localparam logic [2:0] ST_MON  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [EPOCH_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [5:0]         sec_reg, sec_next;
    logic [5:0]         min_reg, min_next;
    logic [4:0]         hr_reg, hr_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [3:0]         mon_reg, mon_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg, m_tdata_next;

    logic [REM_W-1:0]   divisor;
    logic [REM_W:0]     trial;
    logic               ge;
    logic [REM_W:0]     rem_sub;
    logic [REM_W-1:0]   rem_step;
    logic [EPOCH_W-1:0] quo_step;
    logic [REM_W-1:0]   ylen;
    logic               leap;
    logic [DAY_W-1:0]   doy;
    logic [4:0]         mlen;
    logic               s_accept;
    logic               out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Divisor of the current division phase.
    always_comb begin
        case (phase_reg)
            PH_QUAD: divisor = DIV_QUAD;
            PH_HOUR: divisor = DIV_DAY;
            default: divisor = DIV_MINUTE;
        endcase
    end

    // One restoring division step: shift in the next dividend bit, try a subtract.
    always_comb begin
        trial    = {rem_reg, quo_reg[EPOCH_W-1]};
        ge       = (trial >= {1'b0, divisor});
        rem_sub  = trial - {1'b0, divisor};
        rem_step = ge ? rem_sub[REM_W-1:0] : trial[REM_W-1:0];
        quo_step = {quo_reg[EPOCH_W-2:0], ge};
    end

    // Calendar helpers.
    assign leap = (year_reg[1:0] == 2'b00);
    assign ylen = leap ? HOURS_LEAP : HOURS_YEAR;
    assign doy  = quo_step[DAY_W-1:0] + DAY_W'(1);
    assign mlen = month_len(mon_reg);

    // Sequencer of divisions, year steps and month walk.
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        sec_next      = sec_reg;
        min_next      = min_reg;
        hr_next       = hr_reg;
        year_next     = year_reg;
        day_next      = day_reg;
        mon_next      = mon_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    quo_next   = s_tdata;
                    rem_next   = '0;
                    cnt_next   = 6'd32;
                    phase_next = PH_SEC;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    rem_next = '0;
                    case (phase_reg)
                        PH_SEC: begin
                            // Minutes fit in 27 bits; align them to the top.
                            sec_next   = rem_step[5:0];
                            quo_next   = {quo_step[26:0], 5'b0};
                            cnt_next   = 6'd27;
                            phase_next = PH_MIN;
                        end
                        PH_MIN: begin
                            // Hours fit in 21 bits.
                            min_next   = rem_step[5:0];
                            quo_next   = {quo_step[20:0], 11'b0};
                            cnt_next   = 6'd21;
                            phase_next = PH_QUAD;
                        end
                        PH_QUAD: begin
                            // Four years per block; hours left stay in the remainder.
                            year_next  = BASE_YEAR + {4'b0, quo_step[5:0], 2'b00};
                            rem_next   = rem_step;
                            state_next = ST_YEAR;
                        end
                        default: begin
                            // Hour of day and day of year; leap day is settled here.
                            hr_next  = rem_step[4:0];
                            mon_next = 4'd0;
                            if (leap && doy == DAY_W'(60)) begin
                                mon_next   = 4'd1;
                                day_next   = DAY_W'(29);
                                state_next = ST_DONE;
                            end else begin
                                day_next   = (leap && doy > DAY_W'(60)) ?
                                             doy - DAY_W'(1) : doy;
                                state_next = ST_MON;
                            end
                        end
                    endcase
                end
            end
            ST_YEAR: begin
                if (rem_reg < ylen) begin
                    quo_next   = {rem_reg, 16'b0};
                    rem_next   = '0;
                    cnt_next   = 6'd16;
                    phase_next = PH_HOUR;
                    state_next = ST_DIV;
                end else begin
                    year_next = year_reg + YEAR_W'(1);
                    rem_next  = rem_reg - ylen;
                end
            end
            ST_MON: begin
                if (mon_reg < 4'd11 && {4'b0, mlen} < day_reg) begin
                    day_next = day_reg - {4'b0, mlen};
                    mon_next = mon_reg + 4'd1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, year_reg, mon_reg, day_reg[4:0],
                                     hr_reg, min_reg, sec_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        phase_reg   <= phase_next;
        cnt_reg     <= cnt_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        sec_reg     <= sec_next;
        min_reg     <= min_next;
        hr_reg      <= hr_next;
        year_reg    <= year_next;
        day_reg     <= day_next;
        mon_reg     <= mon_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Checks on the sequencer and the result.
    `ASSERT_NEXT(a_accept_starts_div, s_accept, state_reg == ST_DIV && phase_reg == PH_SEC)
    `ASSERT_IMPL(a_div_count_live, state_reg == ST_DIV, cnt_reg != 6'd0)
    `ASSERT_IMPL(a_month_range, state_reg == ST_MON || state_reg == ST_DONE, mon_reg <= 4'd11)
    `ASSERT_IMPL(a_year_range, m_tvalid_reg, m_tdata_reg[37:26] >= 12'd1970 && m_tdata_reg[37:26] <= 12'd2106)

endmodule

/* tb/calendar_checker.sv */
`timescale 1ns / 1ps
// Checker for the epoch-to-calendar converter: predicts each calendar word from
// the accepted epoch word and compares the result words field by field.
// Depends on es2c_pkg for the field widths.
module calendar_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,
    output int unsigned       mismatch_count,
    output int unsigned       words_pending
);
    import es2c_pkg::*;

    // Result word layout, highest field first so that it maps onto m_tdata.
    typedef struct packed {
        logic [1:0]        zero;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month_index;
        logic [4:0]        day_of_month;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } calendar_t;

    localparam int unsigned SECS_PER_MIN   = 60;
    localparam int unsigned HOURS_PER_DAY  = 24;
    localparam int unsigned HOURS_PER_QUAD = 35064;
    localparam int unsigned HOURS_COMMON   = 8760;
    localparam int unsigned FIRST_YEAR     = 1970;
    localparam int unsigned LEAP_DAY       = 60;
    localparam int unsigned DECEMBER       = 11;

    logic [4:0]  days_in_month [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    calendar_t   dates_due [$];
    int unsigned mismatches = 0;

    assign mismatch_count = mismatches;
    assign words_pending  = dates_due.size();

    // Break the epoch count down into calendar fields. Every year divisible by
    // four is taken as a leap year, which makes 2100 a leap year too.
    function automatic calendar_t calendar_of(input logic [EPOCH_W-1:0] epoch);
        calendar_t   cal;
        int unsigned rest;
        int unsigned yr;
        int unsigned year_hours;
        int unsigned yday;
        logic [3:0]  mon;
        rest = epoch;
        cal = '0;
        cal.second = 6'(rest % SECS_PER_MIN);
        rest = rest / SECS_PER_MIN;
        cal.minute = 6'(rest % SECS_PER_MIN);
        rest = rest / SECS_PER_MIN;

        // Whole four-year blocks first, then at most three single years.
        yr = FIRST_YEAR + 4 * (rest / HOURS_PER_QUAD);
        rest = rest % HOURS_PER_QUAD;
        forever begin
            year_hours = HOURS_COMMON + ((yr % 4 == 0) ? HOURS_PER_DAY : 0);
            if (rest < year_hours) break;
            rest = rest - year_hours;
            yr++;
        end

        cal.hour = 5'(rest % HOURS_PER_DAY);
        yday = rest / HOURS_PER_DAY + 1;
        mon = 4'd0;

        // The leap day is settled directly; later days of a leap year shift
        // back by one so the common-year month table applies.
        if (yr % 4 == 0 && yday == LEAP_DAY) begin
            mon = 4'd1;
            yday = 29;
        end else begin
            if (yr % 4 == 0 && yday > LEAP_DAY) yday--;
            while (mon < DECEMBER && days_in_month[mon] < yday) begin
                yday = yday - days_in_month[mon];
                mon++;
            end
        end
        cal.day_of_month = 5'(yday);
        cal.month_index  = mon;
        cal.year         = YEAR_W'(yr);
        return cal;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Predict on every accepted epoch word, compare on every accepted result word.
    always @(posedge aclk) begin
        calendar_t want;
        calendar_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) dates_due.push_back(calendar_of(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (dates_due.size() == 0) begin
                    $error("result word 0x%010h arrived with no epoch word pending", m_tdata);
                    mismatches++;
                end else begin
                    want = dates_due.pop_front();
                    check_field("second", 32'(want.second), 32'(got.second));
                    check_field("minute", 32'(want.minute), 32'(got.minute));
                    check_field("hour", 32'(want.hour), 32'(got.hour));
                    check_field("day_of_month", 32'(want.day_of_month),
                                32'(got.day_of_month));
                    check_field("month_index", 32'(want.month_index),
                                32'(got.month_index));
                    check_field("year", 32'(want.year), 32'(got.year));
                    check_field("zero", 32'(want.zero), 32'(got.zero));
                end
            end
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the epoch-to-calendar testbench: clock, reset, epoch words and backpressure.
// Depends on epoch_seconds_to_calendar, calendar_checker and es2c_pkg.
module tb_top;
    import es2c_pkg::*;

    localparam int unsigned RANDOM_WORDS  = 700;
    localparam int unsigned IDLE_LIGHT    = 18;
    localparam int unsigned IDLE_HEAVY    = 88;
    localparam int unsigned DRAIN_CYCLES  = 150;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned LAST_FULL_DAY = 49710;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [EPOCH_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [39:0]        m_tdata;
    int unsigned        mismatch_count;
    int unsigned        words_pending;
    int unsigned        send_idle_pct = IDLE_LIGHT;
    int unsigned        recv_idle_pct = IDLE_HEAVY;

    // Calendar landmarks: field extremes, minute/hour/day edges, year and
    // four-year block edges, the leap day in 1972, 2000 and 2100, the first
    // day after those in 1972 and 2100, and the largest count.
    logic [EPOCH_W-1:0] landmarks [$] = '{
        32'd0,          32'd59,         32'd60,         32'd3599,
        32'd3600,       32'd86399,      32'd86400,      32'd31535999,
        32'd36633600,   32'd68169599,   32'd68169600,   32'd68255999,
        32'd68256000,   32'd94694399,   32'd94694400,   32'd126230399,
        32'd126230400,  32'd951782400,  32'd2147483647, 32'd4107542400,
        32'd4107628800, 32'hFFFF_FFFF
    };

    epoch_seconds_to_calendar dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    calendar_checker calendar_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver backpressure, redrawn every cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Offer one epoch word after a random number of idle cycles and hold it
    // until the block takes it. Called and returns at a falling edge.
    task automatic send_epoch(input logic [EPOCH_W-1:0] value);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Half the words are any 32-bit count; the rest sit on or next to a
    // midnight, where day, month and year roll over.
    function automatic logic [EPOCH_W-1:0] random_epoch();
        logic [63:0] midnight;
        if ($urandom_range(1, 0) == 0) return $urandom;
        midnight = 64'($urandom_range(LAST_FULL_DAY, 0)) * SECS_PER_DAY;
        case ($urandom_range(2, 0))
            0:       return midnight[EPOCH_W-1:0];
            1:       return midnight[EPOCH_W-1:0] - 32'd1;
            default: return midnight[EPOCH_W-1:0] + $urandom_range(3599, 0);
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words with a slow receiver.
        foreach (landmarks[i]) send_epoch(landmarks[i]);
        for (int i = 0; i < RANDOM_WORDS / 3; i++) send_epoch(random_epoch());

        // Slow sender, mostly ready receiver.
        send_idle_pct = IDLE_HEAVY;
        recv_idle_pct = IDLE_LIGHT;
        for (int i = 0; i < RANDOM_WORDS / 3; i++) send_epoch(random_epoch());

        // Both sides at full rate.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_WORDS - 2 * (RANDOM_WORDS / 3); i++) begin
            send_epoch(random_epoch());
        end
        s_tvalid <= 1'b0;

        wait (words_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && words_pending == 0) begin
            $display("epoch_seconds_to_calendar verification clean");
        end else begin
            $display("epoch_seconds_to_calendar verification failed");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("epoch_seconds_to_calendar verification failed");
        $finish;
    end

endmodule
